### rtl/core/kct_pkg.sv
// ----------------------------------------------------------------------------
// kct_pkg: shared types and constants of the keypad countdown timer
// Payload structs, command and status codes, mode encoding, timing constants.
// ----------------------------------------------------------------------------
package kct_pkg;

   localparam int unsigned NUM_DIGITS = 6;

   // command codes of a request item
   localparam logic [2:0] CMD_DIGIT  = 3'd0;
   localparam logic [2:0] CMD_CLEAR  = 3'd1;
   localparam logic [2:0] CMD_TOGGLE = 3'd2;
   localparam logic [2:0] CMD_STOP   = 3'd3;
   localparam logic [2:0] CMD_TICK   = 3'd4;

   // status codes of a response item
   localparam logic [1:0] STATUS_IDLE     = 2'd0;
   localparam logic [1:0] STATUS_RUNNING  = 2'd1;
   localparam logic [1:0] STATUS_PAUSED   = 2'd2;
   localparam logic [1:0] STATUS_FINISHED = 2'd3;

   localparam logic [3:0]  MAX_DIGIT = 4'd9;
   localparam logic [6:0]  MAX_FIELD = 7'd59;
   localparam logic [15:0] TPS_RESET = 16'd1000;

   // configuration register map (byte address bit 2 selects the word)
   localparam int unsigned CSR_ADDR_W = 3;
   localparam logic       CSR_IDX_TPS = 1'b0;

   typedef enum logic [3:0] {
      MODE_IDLE     = 4'b0001,
      MODE_RUNNING  = 4'b0010,
      MODE_PAUSED   = 4'b0100,
      MODE_FINISHED = 4'b1000
   } mode_type;

   typedef struct packed {
      logic [2:0] command;
      logic [3:0] digit;
   } req_type;

   typedef struct packed {
      logic [6:0] hours;
      logic [6:0] minutes;
      logic [6:0] seconds;
      logic [1:0] status;
      logic       buzzer_start;
      logic       buzzer_stop;
      logic       idle_and_empty;
   } rsp_type;

endpackage

### rtl/core/kct_core.sv
// ----------------------------------------------------------------------------
// kct_core: timer state and per-item update
// Holds entry digits, mode, remaining time (hours/minutes/seconds) and the
// sub-second count; forms the response of the item from the updated state.
// ----------------------------------------------------------------------------
module kct_core
   import kct_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        accept,
   input  req_type     req_data,
   input  logic [15:0] ticks_per_second,
   output rsp_type     result
);

   logic [3:0]  digits_ff [NUM_DIGITS];
   logic [3:0]  digits_in [NUM_DIGITS];
   mode_type    mode_ff, mode_in;
   logic [6:0]  hrs_ff, hrs_in;
   logic [5:0]  min_ff, min_in;
   logic [5:0]  sec_ff, sec_in;
   logic [15:0] sub_ff, sub_in;

   logic        buzz_start, buzz_stop;
   logic [16:0] sub_next;
   logic [3:0]  dig_sat;
   logic [6:0]  pair_h, pair_m, pair_s;
   logic [6:0]  ent_h, ent_m, ent_s;
   logic        entry_nonzero;

   function automatic logic [6:0] pair_value(input logic [3:0] tens, input logic [3:0] ones);
      return {tens, 3'b000} + {2'b00, tens, 1'b0} + {3'b000, ones};
   endfunction

   function automatic logic [5:0] clamp_field(input logic [6:0] v);
      return (v > MAX_FIELD) ? MAX_FIELD[5:0] : v[5:0];
   endfunction

   assign dig_sat  = (req_data.digit > MAX_DIGIT) ? MAX_DIGIT : req_data.digit;
   assign sub_next = {1'b0, sub_ff} + 17'd1;

   assign ent_h = pair_value(digits_ff[0], digits_ff[1]);
   assign ent_m = pair_value(digits_ff[2], digits_ff[3]);
   assign ent_s = pair_value(digits_ff[4], digits_ff[5]);
   assign entry_nonzero = (ent_h != 7'd0) || (ent_m != 7'd0) || (ent_s != 7'd0);

   always_comb begin
      digits_in  = digits_ff;
      mode_in    = mode_ff;
      hrs_in     = hrs_ff;
      min_in     = min_ff;
      sec_in     = sec_ff;
      sub_in     = sub_ff;
      buzz_start = 1'b0;
      buzz_stop  = 1'b0;

      case (req_data.command)
         CMD_DIGIT: begin
            if (mode_ff == MODE_IDLE) begin
               for (int i = 0; i < NUM_DIGITS - 1; i++) begin
                  digits_in[i] = digits_ff[i + 1];
               end
               digits_in[NUM_DIGITS - 1] = dig_sat;
            end
         end
         CMD_CLEAR: begin
            if (mode_ff == MODE_IDLE) begin
               for (int i = 0; i < NUM_DIGITS; i++) begin
                  digits_in[i] = 4'd0;
               end
            end
         end
         CMD_TOGGLE: begin
            unique case (mode_ff)
               MODE_IDLE: begin
                  if (entry_nonzero) begin
                     hrs_in  = ent_h;
                     min_in  = clamp_field(ent_m);
                     sec_in  = clamp_field(ent_s);
                     mode_in = MODE_RUNNING;
                     sub_in  = 16'd0;
                  end
               end
               MODE_RUNNING: mode_in = MODE_PAUSED;
               MODE_PAUSED: begin
                  mode_in = MODE_RUNNING;
                  sub_in  = 16'd0;
               end
               MODE_FINISHED: begin
                  mode_in   = MODE_IDLE;
                  hrs_in    = 7'd0;
                  min_in    = 6'd0;
                  sec_in    = 6'd0;
                  sub_in    = 16'd0;
                  buzz_stop = 1'b1;
                  for (int i = 0; i < NUM_DIGITS; i++) begin
                     digits_in[i] = 4'd0;
                  end
               end
               default: mode_in = mode_ff;
            endcase
         end
         CMD_STOP: begin
            mode_in   = MODE_IDLE;
            hrs_in    = 7'd0;
            min_in    = 6'd0;
            sec_in    = 6'd0;
            sub_in    = 16'd0;
            buzz_stop = 1'b1;
            for (int i = 0; i < NUM_DIGITS; i++) begin
               digits_in[i] = 4'd0;
            end
         end
         CMD_TICK: begin
            if (mode_ff == MODE_RUNNING) begin
               if (sub_next >= {1'b0, ticks_per_second}) begin
                  sub_in = 16'd0;
                  // borrow through seconds, minutes, hours
                  if (sec_ff != 6'd0) begin
                     sec_in = sec_ff - 6'd1;
                  end else if (min_ff != 6'd0) begin
                     min_in = min_ff - 6'd1;
                     sec_in = MAX_FIELD[5:0];
                  end else if (hrs_ff != 7'd0) begin
                     hrs_in = hrs_ff - 7'd1;
                     min_in = MAX_FIELD[5:0];
                     sec_in = MAX_FIELD[5:0];
                  end
                  if ((hrs_in == 7'd0) && (min_in == 6'd0) && (sec_in == 6'd0)) begin
                     mode_in    = MODE_FINISHED;
                     buzz_start = 1'b1;
                  end
               end else begin
                  sub_in = sub_next[15:0];
               end
            end
         end
         default: begin
         end
      endcase
   end

   // response reflects the state after the item
   assign pair_h = pair_value(digits_in[0], digits_in[1]);
   assign pair_m = pair_value(digits_in[2], digits_in[3]);
   assign pair_s = pair_value(digits_in[4], digits_in[5]);

   always_comb begin
      result.buzzer_start   = buzz_start;
      result.buzzer_stop    = buzz_stop;
      result.idle_and_empty = 1'b0;
      if (mode_in == MODE_IDLE) begin
         result.hours          = pair_h;
         result.minutes        = pair_m;
         result.seconds        = pair_s;
         result.idle_and_empty = (pair_h == 7'd0) && (pair_m == 7'd0) && (pair_s == 7'd0);
      end else begin
         result.hours   = hrs_in;
         result.minutes = {1'b0, min_in};
         result.seconds = {1'b0, sec_in};
      end
      unique case (mode_in)
         MODE_IDLE:     result.status = STATUS_IDLE;
         MODE_RUNNING:  result.status = STATUS_RUNNING;
         MODE_PAUSED:   result.status = STATUS_PAUSED;
         MODE_FINISHED: result.status = STATUS_FINISHED;
         default:       result.status = STATUS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         hrs_ff  <= 7'd0;
         min_ff  <= 6'd0;
         sec_ff  <= 6'd0;
         sub_ff  <= 16'd0;
         for (int i = 0; i < NUM_DIGITS; i++) begin
            digits_ff[i] <= 4'd0;
         end
      end else if (accept) begin
         mode_ff   <= mode_in;
         hrs_ff    <= hrs_in;
         min_ff    <= min_in;
         sec_ff    <= sec_in;
         sub_ff    <= sub_in;
         digits_ff <= digits_in;
      end
   end

endmodule

### rtl/core/keypad_countdown_timer_unit.sv
// ----------------------------------------------------------------------------
// keypad_countdown_timer_unit: HH:MM:SS countdown timer with keypad entry
// Takes digit, clear, start/pause, stop and tick items; gives one display
// item per request with mode and buzzer flags.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------
//  req     | in        | req_valid/req_stall  | req_type: command, digit
//  rsp     | out       | rsp_valid/rsp_stall  | rsp_type: h, m, s, status, flags
//  csr     | in/out    | APB psel/penable     | ticks_per_second at byte 0
//
//  One item per cycle while req_stall is low: the state update is a
//  single pass of shallow logic; the response is registered on accept.
//  A two-entry output buffer (output register plus skid) lets a new item
//  in while a finished response waits; req_stall rises only when both hold.
//  Reset (synchronous) clears digits, mode, remaining time, sub-second
//  count and the buffer, and sets ticks_per_second to 1000.
//
module keypad_countdown_timer_unit
   import kct_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   // response channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   // configuration port
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   logic [15:0] tps_ff;
   logic        csr_write;
   logic        accept;
   logic        pop;
   rsp_type     result;

   // output buffer: head register and skid register
   rsp_type     head_ff;
   rsp_type     skid_ff;
   logic [1:0]  count_ff;

   // configuration: writes complete in the access phase, pready tied high
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         tps_ff <= TPS_RESET;
      end else if (csr_write && (paddr[2] == CSR_IDX_TPS)) begin
         tps_ff <= pwdata[15:0];
      end
   end

   always_comb begin
      prdata = 32'd0;
      if (paddr[2] == CSR_IDX_TPS) begin
         prdata = {16'd0, tps_ff};
      end
   end

   // handshake: stall only when both buffer entries are occupied
   assign req_stall = (count_ff == 2'd2);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = (count_ff != 2'd0);
   assign pop       = rsp_valid && !rsp_stall;
   assign rsp_data  = head_ff;

   kct_core u_core (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .req_data         (req_data),
      .ticks_per_second (tps_ff),
      .result           (result)
   );

   // buffer control: fill head first, park in skid when head is stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         case (count_ff)
            2'd0: begin
               if (accept) begin
                  count_ff <= 2'd1;
               end
            end
            2'd1: begin
               if (accept && !pop) begin
                  count_ff <= 2'd2;
               end else if (!accept && pop) begin
                  count_ff <= 2'd0;
               end
            end
            2'd2: begin
               if (pop) begin
                  count_ff <= 2'd1;
               end
            end
            default: count_ff <= 2'd0;
         endcase
      end
   end

   // payload registers: no reset needed
   always_ff @(posedge clock) begin
      case (count_ff)
         2'd0: begin
            if (accept) begin
               head_ff <= result;
            end
         end
         2'd1: begin
            if (accept && pop) begin
               head_ff <= result;
            end else if (accept) begin
               skid_ff <= result;
            end
         end
         2'd2: begin
            if (pop) begin
               head_ff <= skid_ff;
            end
         end
         default: begin
         end
      endcase
   end

endmodule

### rtl/core/kct_checker.sv
// ----------------------------------------------------------------------------
// kct_checker: port-level checks of the countdown timer
// Response handshake, buzzer flags and display consistency, reset behavior.
// ----------------------------------------------------------------------------
module kct_checker
   import kct_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // a stalled response item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response item changed or dropped");

   // no response item comes out right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // a buzzer start means the countdown just ran out
   a_buzz_start: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.buzzer_start |->
         rsp_data.status == STATUS_FINISHED && !rsp_data.buzzer_stop &&
         rsp_data.hours == 7'd0 && rsp_data.minutes == 7'd0 && rsp_data.seconds == 7'd0)
      else $error("buzzer start without finished countdown");

   // a stop always lands in idle with cleared digits
   a_buzz_stop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.buzzer_stop |->
         rsp_data.status == STATUS_IDLE && rsp_data.idle_and_empty)
      else $error("buzzer stop without cleared idle state");

   // empty flag only in idle with an all-zero display
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.idle_and_empty |->
         rsp_data.status == STATUS_IDLE &&
         rsp_data.hours == 7'd0 && rsp_data.minutes == 7'd0 && rsp_data.seconds == 7'd0)
      else $error("empty flag with nonzero display or not idle");

endmodule

bind keypad_countdown_timer_unit kct_checker u_kct_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
